// ===== rtl/pwmtick_pkg.sv =====
// shared constants and types for the pwm ns to timer tick converter
// no dependencies; used by rtl/pwm_ns_to_timer_ticks.sv
package pwmtick_pkg;

  localparam int COUNTER_BITS_DEF   = 16;
  localparam int PRESCALE_LIMIT_DEF = 6;

  localparam int NS_W       = 32;
  localparam int RATE_W     = 28;
  localparam int TICK_W     = 30;
  localparam int STATUS_W   = 2;
  localparam int PRESCALE_W = 3;

  localparam logic [RATE_W-1:0] RATE_RESET = 28'd12000000;
  localparam logic [TICK_W-1:0] NS_PER_SEC = 30'd1000000000;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_DUTY_BAD   = 2'd1,
    STATUS_TOO_LONG   = 2'd2,
    STATUS_ZERO_TICKS = 2'd3
  } status_t;

endpackage

// ===== rtl/pwm_ns_to_timer_ticks.sv =====
// pwm duty/period in nanoseconds to prescaler select and timer counts
// depends on rtl/pwmtick_pkg.sv
//
// usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the timer clock rate in hz;
//   cfg_ready is always high, reset value is 12 MHz. write only while idle.
//   in channel carries one item: duty_time_ns and period_time_ns, signed.
//   out channel returns one item per input: status, prescale select,
//   period ticks and duty ticks; on any error status the other fields are zero.
// timing:
//   one item at a time through one shift-add multiplier and one restoring
//   divider, both one bit per cycle. ticks = rate * period / 1e9 uses
//   31 multiply steps and 31+PW divide steps (PW = max(30, COUNTER_BITS)),
//   then prescale steps that shift period ticks right by two, and a check;
//   the same multiplier and divider then give duty = duty_ns * ticks / period_ns,
//   and the result enters the output register once it is free. a bad duty skips the arithmetic.
//   in_tready rises as the result enters the output register, so the next
//   item may start while a result waits on a stalled receiver; a second
//   result waits until the first is taken.
// reset: synchronous, clears control state and reloads the clock rate.
module pwm_ns_to_timer_ticks #(
  parameter int COUNTER_BITS   = pwmtick_pkg::COUNTER_BITS_DEF,
  parameter int PRESCALE_LIMIT = pwmtick_pkg::PRESCALE_LIMIT_DEF,
  localparam int OUT_W = ((pwmtick_pkg::STATUS_W + pwmtick_pkg::PRESCALE_W
                          + 2 * COUNTER_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pwmtick_pkg::RATE_W-1:0] cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // duty_time_ns, period_time_ns
  input  logic [2*pwmtick_pkg::NS_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status, prescale_select, period_ticks, duty_ticks, zero pad
  output logic [OUT_W-1:0]               out_tdata
);

  localparam int NS_W    = pwmtick_pkg::NS_W;
  localparam int MAG_W   = NS_W - 1;
  localparam int PW      = (COUNTER_BITS > pwmtick_pkg::TICK_W) ? COUNTER_BITS
                                                                : pwmtick_pkg::TICK_W;
  localparam int MW      = PW + MAG_W;
  localparam int CNT_W   = $clog2(MW + 1);
  localparam int PRE_W   = $clog2(PRESCALE_LIMIT + 1);
  localparam int STAT_W  = pwmtick_pkg::STATUS_W;
  localparam int PSEL_W  = pwmtick_pkg::PRESCALE_W;
  localparam int FIELD_W = STAT_W + PSEL_W + 2 * COUNTER_BITS;
  localparam int PER_LO  = STAT_W + PSEL_W;
  localparam int DUT_LO  = PER_LO + COUNTER_BITS;

  localparam logic [PW-1:0]    CMAX     = PW'((65'd1 << COUNTER_BITS) - 65'd1);
  localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(PRESCALE_LIMIT);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_DIV1, S_SCALE, S_MUL2, S_DIV2, S_FINISH
  } state_t;

  state_t                       state_r;
  logic [pwmtick_pkg::RATE_W-1:0] rate_r;
  logic [MW-1:0]                prod_r;
  logic [MAG_W-1:0]             rem_r;
  logic [PW-1:0]                mpl_r;
  logic [MAG_W-1:0]             pns_r;
  logic [MAG_W-1:0]             dns_r;
  logic [PW-1:0]                per_r;
  logic [PW-1:0]                dut_r;
  logic [PRE_W-1:0]             pre_r;
  logic [CNT_W-1:0]             cnt_r;
  pwmtick_pkg::status_t         status_r;
  logic                         out_valid_r;
  logic [OUT_W-1:0]             out_data_r;

  logic                         in_acc;
  logic                         duty_bad;
  logic [PW:0]                  mul_sum;
  logic [MW-1:0]                prod_mul_nxt;
  logic [MAG_W-1:0]             div_den;
  logic [MAG_W:0]               div_try;
  logic                         div_ge;
  logic [MAG_W:0]               div_diff;
  logic [MW-1:0]                prod_div_nxt;
  logic [MAG_W-1:0]             rem_nxt;
  logic [PW-1:0]                quo;
  logic                         out_free;
  logic [FIELD_W-1:0]           pack;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign duty_bad = in_tdata[NS_W-1] ||
                    ($signed(in_tdata[NS_W-1:0]) > $signed(in_tdata[2*NS_W-1:NS_W]));

  // shift-add multiply, multiplier in the low bits of prod_r
  assign mul_sum      = {1'b0, prod_r[MW-1:MAG_W]} + (prod_r[0] ? {1'b0, mpl_r} : '0);
  assign prod_mul_nxt = {mul_sum, prod_r[MAG_W-1:1]};

  // restoring divide, quotient bits shift in at the bottom
  assign div_den      = (state_r == S_DIV1) ? MAG_W'(pwmtick_pkg::NS_PER_SEC) : pns_r;
  assign div_try      = {rem_r, prod_r[MW-1]};
  assign div_ge       = div_try >= {1'b0, div_den};
  assign div_diff     = div_try - {1'b0, div_den};
  assign rem_nxt      = div_ge ? div_diff[MAG_W-1:0] : div_try[MAG_W-1:0];
  assign prod_div_nxt = {prod_r[MW-2:0], div_ge};
  assign quo          = prod_div_nxt[PW-1:0];

  always_comb begin
    if (status_r == pwmtick_pkg::STATUS_OK) begin
      pack = {dut_r[COUNTER_BITS-1:0], per_r[COUNTER_BITS-1:0], PSEL_W'(pre_r), status_r};
    end else begin
      pack = FIELD_W'(status_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= pwmtick_pkg::RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rate_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            dns_r <= in_tdata[MAG_W-1:0];
            pns_r <= in_tdata[NS_W+MAG_W-1:NS_W];
            if (duty_bad) begin
              status_r <= pwmtick_pkg::STATUS_DUTY_BAD;
              state_r  <= S_FINISH;
            end else begin
              prod_r  <= {{PW{1'b0}}, in_tdata[NS_W+MAG_W-1:NS_W]};
              mpl_r   <= PW'(rate_r);
              cnt_r   <= '0;
              state_r <= S_MUL1;
            end
          end
        end
        S_MUL1, S_MUL2: begin
          prod_r <= prod_mul_nxt;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(MAG_W - 1)) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            state_r <= (state_r == S_MUL1) ? S_DIV1 : S_DIV2;
          end
        end
        S_DIV1: begin
          prod_r <= prod_div_nxt;
          rem_r  <= rem_nxt;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(MW - 1)) begin
            per_r   <= quo;
            pre_r   <= '0;
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (per_r > CMAX && pre_r != PRE_LAST) begin
            per_r <= per_r >> 2;
            pre_r <= pre_r + 1'b1;
          end else if (pre_r == PRE_LAST) begin
            status_r <= pwmtick_pkg::STATUS_TOO_LONG;
            state_r  <= S_FINISH;
          end else if (per_r == '0) begin
            status_r <= pwmtick_pkg::STATUS_ZERO_TICKS;
            state_r  <= S_FINISH;
          end else begin
            prod_r  <= {{PW{1'b0}}, dns_r};
            mpl_r   <= per_r;
            cnt_r   <= '0;
            state_r <= S_MUL2;
          end
        end
        S_DIV2: begin
          prod_r <= prod_div_nxt;
          rem_r  <= rem_nxt;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(MW - 1)) begin
            dut_r    <= (quo >= per_r) ? per_r - 1'b1 : quo;
            status_r <= pwmtick_pkg::STATUS_OK;
            state_r  <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= OUT_W'(pack);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input accepted twice without finishing");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[STAT_W-1:0] != pwmtick_pkg::STATUS_OK
      |-> out_tdata[OUT_W-1:STAT_W] == '0)
    else $error("error result carries nonzero fields");

  a_duty_below_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[STAT_W-1:0] == pwmtick_pkg::STATUS_OK
      |-> out_tdata[DUT_LO+COUNTER_BITS-1:DUT_LO] < out_tdata[DUT_LO-1:PER_LO])
    else $error("duty ticks not below period ticks");

  a_prescale_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[STAT_W-1:0] == pwmtick_pkg::STATUS_OK
      |-> int'(out_tdata[PER_LO-1:STAT_W]) < PRESCALE_LIMIT)
    else $error("prescale select at or above limit on ok result");

endmodule
